/* sv/spl_pkg.sv */
// Package for the sliding peak soft limiter: types, codes, reset values.
// Used by spl_ctrl, spl_dp and sliding_peak_soft_limiter_unit.
`default_nettype none
package spl_pkg;

  localparam int MAX_WINDOW_DEF = 16384;

  localparam logic [30:0] THRESHOLD_RST  = 31'd28671;
  localparam logic [30:0] CEILING_RST    = 31'd32767;
  localparam logic [30:0] INPUT_PEAK_RST = 31'h7fffffff;
  localparam logic [14:0] WINDOW_LEN_RST = 15'd9600;

  typedef enum logic [1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_CEILING    = 2'd1,
    REG_INPUT_PEAK = 2'd2,
    REG_WINDOW_LEN = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [30:0] threshold;
    logic [30:0] ceiling;
    logic [30:0] input_peak;
    logic [14:0] window_len;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_CT_PT     = 3'd0,
    MUL_T_SPAN    = 3'd1,
    MUL_SPAN_PEAK = 3'd2,
    MUL_S_LO      = 3'd3,
    MUL_S_HI      = 3'd4
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     rd_head;
    logic     pop_back;
    logic     push;
    logic     pop_head;
    logic     take_peak;
    logic     enter_bypass;
    logic     leave_bypass;
    logic     mark_gain;
    mul_sel_t mul_sel;
    logic     num_load;
    logic     num_add;
    logic     den_load;
    logic     acc_lo;
    logic     acc_hi;
    logic     div_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic pass_now;
    logic count_zero;
    logic back_pop;
    logic head_old;
    logic peak_low;
    logic gain_ok;
    logic div_last;
    logic out_free;
  } st_t;

endpackage
`default_nettype wire

/* sv/sliding_peak_soft_limiter_unit.sv */
// Top level of the sliding peak soft limiter: configuration registers and
// the controller/datapath pair. Depends on spl_pkg, spl_ctrl and spl_dp.
//
//   channel | signals                           | width
//   input   | in_valid, in_stall, sample        | 32 signed
//   output  | out_valid, out_stall, limited,    | 32 signed
//           | limiting                          | 1
//   config  | cfg_write, cfg_index, cfg_data    | 2 / 31
//
// A bypassed sample below threshold goes from the check straight to the
// output. A tracked sample reads and pops back entries, is pushed, then reads
// and pops stale head entries, and when gain is applied runs the shared 33x33
// multiplier and its accumulators, then 96 steps of the restoring divider.
// Reset clears the queue pointers, the sample counter and sets bypass; the
// queue memory itself is not cleared. A result waits in the output register
// while the next word is taken; in_stall is high while a word is in work, and
// a finished word holds until the output register is free.
`default_nettype none
module sliding_peak_soft_limiter_unit #(
  parameter int MAX_WINDOW = spl_pkg::MAX_WINDOW_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      limited,
  output logic             limiting,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);

  spl_pkg::cfg_t cfg;
  spl_pkg::cmd_t cmd;
  spl_pkg::st_t  st;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold  <= spl_pkg::THRESHOLD_RST;
      cfg.ceiling    <= spl_pkg::CEILING_RST;
      cfg.input_peak <= spl_pkg::INPUT_PEAK_RST;
      cfg.window_len <= spl_pkg::WINDOW_LEN_RST;
    end else if (cfg_write) begin
      unique case (spl_pkg::reg_idx_t'(cfg_index))
        spl_pkg::REG_THRESHOLD:  cfg.threshold  <= cfg_data;
        spl_pkg::REG_CEILING:    cfg.ceiling    <= cfg_data;
        spl_pkg::REG_INPUT_PEAK: cfg.input_peak <= cfg_data;
        spl_pkg::REG_WINDOW_LEN: cfg.window_len <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  spl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  spl_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .st        (st),
    .sample    (sample),
    .limited   (limited),
    .limiting  (limiting),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule
`default_nettype wire

/* sv/spl_ctrl.sv */
// Controller state machine of the limiter: sequences queue upkeep, multiplies
// and the division. Depends on spl_pkg; drives spl_dp through cmd_t.
`default_nettype none
module spl_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire spl_pkg::st_t st,
  output spl_pkg::cmd_t     cmd
);

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_CHECK     = 17'h00002,
    S_BACK_RD   = 17'h00004,
    S_BACK_CMP  = 17'h00008,
    S_PUSH      = 17'h00010,
    S_FRONT_RD  = 17'h00020,
    S_FRONT_CMP = 17'h00040,
    S_PEAK      = 17'h00080,
    S_MUL_A     = 17'h00100,
    S_MUL_B     = 17'h00200,
    S_MUL_C     = 17'h00400,
    S_MUL_D     = 17'h00800,
    S_MUL_E     = 17'h01000,
    S_MUL_F     = 17'h02000,
    S_MUL_G     = 17'h04000,
    S_DIVIDE    = 17'h08000,
    S_DONE      = 17'h10000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mul_sel = spl_pkg::MUL_CT_PT;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = st.pass_now ? S_DONE : S_BACK_RD;
      end
      S_BACK_RD: begin
        state_next = st.count_zero ? S_PUSH : S_BACK_CMP;
      end
      S_BACK_CMP: begin
        if (st.back_pop) begin
          cmd.pop_back = 1'b1;
          state_next = S_BACK_RD;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        state_next = S_FRONT_RD;
      end
      S_FRONT_RD: begin
        cmd.rd_head = 1'b1;
        state_next = st.count_zero ? S_DONE : S_FRONT_CMP;
      end
      S_FRONT_CMP: begin
        cmd.rd_head = 1'b1;
        if (st.head_old) begin
          cmd.pop_head = 1'b1;
          state_next = S_FRONT_RD;
        end else begin
          cmd.take_peak = 1'b1;
          state_next = S_PEAK;
        end
      end
      S_PEAK: begin
        if (st.peak_low) begin
          cmd.enter_bypass = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.leave_bypass = 1'b1;
          if (st.gain_ok) begin
            cmd.mark_gain = 1'b1;
            state_next = S_MUL_A;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_MUL_A: begin
        cmd.mul_sel = spl_pkg::MUL_CT_PT;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_sel = spl_pkg::MUL_T_SPAN;
        cmd.num_load = 1'b1;
        state_next = S_MUL_C;
      end
      S_MUL_C: begin
        cmd.mul_sel = spl_pkg::MUL_SPAN_PEAK;
        cmd.num_add = 1'b1;
        state_next = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.den_load = 1'b1;
        state_next = S_MUL_E;
      end
      S_MUL_E: begin
        cmd.mul_sel = spl_pkg::MUL_S_LO;
        state_next = S_MUL_F;
      end
      S_MUL_F: begin
        cmd.mul_sel = spl_pkg::MUL_S_HI;
        cmd.acc_lo = 1'b1;
        state_next = S_MUL_G;
      end
      S_MUL_G: begin
        cmd.acc_hi = 1'b1;
        state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/spl_dp.sv */
// Datapath of the limiter: peak queue memory, pointers, shared multiplier,
// restoring divider and output register. Depends on spl_pkg.
`default_nettype none
module spl_dp #(
  parameter int MAX_WINDOW = spl_pkg::MAX_WINDOW_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire spl_pkg::cfg_t cfg,
  input  wire spl_pkg::cmd_t cmd,
  output spl_pkg::st_t       st,
  input  wire logic [31:0]   sample,
  output logic [31:0]        limited,
  output logic               limiting,
  output logic               out_valid,
  input  wire logic          out_stall
);

  localparam int QCAP = MAX_WINDOW + 2;
  localparam int PW   = $clog2(QCAP);
  localparam int CW   = $clog2(QCAP + 1);

  logic [47:0]   mem [QCAP];
  logic [47:0]   rdata;
  logic [PW-1:0] head, tail, back, rd_addr;
  logic [CW-1:0] count;
  logic          bypassed;

  logic [31:0] s_reg;
  logic [15:0] cnt;
  logic [31:0] mag;
  logic [31:0] peak;
  logic        gain_on;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [64:0] num;
  logic [63:0] den, nmag;
  logic [95:0] acc;
  logic [63:0] rem, rem_shift;
  logic [32:0] quo;
  logic [33:0] quo_shift;
  logic [6:0]  dcnt;
  logic        do_sub;

  logic [30:0] span;
  logic [16:0] w_eff;
  logic [15:0] age;
  logic [32:0] q_neg;
  logic [31:0] res;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(QCAP - 1)) ? '0 : p + PW'(1);
  endfunction

  assign back    = (tail == '0) ? PW'(QCAP - 1) : tail - PW'(1);
  assign rd_addr = cmd.rd_head ? head : back;
  assign span    = cfg.input_peak - cfg.threshold;
  assign w_eff   = ({2'b00, cfg.window_len} > 17'(MAX_WINDOW)) ? 17'(MAX_WINDOW)
                                                               : {2'b00, cfg.window_len};
  assign age     = cnt - rdata[47:32];

  always_ff @(posedge clk) begin
    if (cmd.push && count != CW'(QCAP)) begin
      mem[tail] <= {cnt, mag};
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      bypassed <= 1'b1;
      cnt      <= '0;
    end else begin
      if (cmd.load) begin
        cnt <= cnt + 16'd1;
      end
      if (cmd.pop_back) begin
        tail  <= back;
        count <= count - CW'(1);
      end
      if (cmd.push && count != CW'(QCAP)) begin
        tail  <= wrap_inc(tail);
        count <= count + CW'(1);
      end
      if (cmd.pop_head) begin
        head  <= wrap_inc(head);
        count <= count - CW'(1);
      end
      if (cmd.enter_bypass) begin
        bypassed <= 1'b1;
        head     <= '0;
        tail     <= '0;
        count    <= '0;
      end
      if (cmd.leave_bypass) begin
        bypassed <= 1'b0;
      end
    end
  end

  // The shared multiplier runs every cycle; the controller picks its operands.
  always_comb begin
    case (cmd.mul_sel)
      spl_pkg::MUL_CT_PT: begin
        ma = $signed({2'b00, cfg.ceiling} - {2'b00, cfg.threshold});
        mb = $signed({1'b0, peak} - {2'b00, cfg.threshold});
      end
      spl_pkg::MUL_T_SPAN: begin
        ma = $signed({2'b00, cfg.threshold});
        mb = $signed({2'b00, span});
      end
      spl_pkg::MUL_SPAN_PEAK: begin
        ma = $signed({2'b00, span});
        mb = $signed({1'b0, peak});
      end
      spl_pkg::MUL_S_LO: begin
        ma = $signed({1'b0, mag});
        mb = $signed({1'b0, nmag[31:0]});
      end
      spl_pkg::MUL_S_HI: begin
        ma = $signed({1'b0, mag});
        mb = $signed({1'b0, nmag[63:32]});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign rem_shift = {rem[62:0], acc[95]};
  assign do_sub    = (rem_shift >= den);
  assign quo_shift = {quo, do_sub};

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (cmd.load) begin
      s_reg   <= sample;
      mag     <= sample[31] ? 32'd0 - sample : sample;
      gain_on <= 1'b0;
    end
    if (cmd.take_peak) begin
      peak <= rdata[31:0];
    end
    if (cmd.mark_gain) begin
      gain_on <= 1'b1;
    end
    if (cmd.num_load) begin
      num <= prod[64:0];
    end
    if (cmd.num_add) begin
      num <= num + prod[64:0];
    end
    if (cmd.den_load) begin
      den  <= prod[63:0];
      nmag <= num[64] ? 64'(-num) : num[63:0];
    end
    if (cmd.acc_lo) begin
      acc <= {32'd0, prod[63:0]};
    end
    if (cmd.acc_hi) begin
      acc  <= acc + {prod[63:0], 32'd0};
      rem  <= '0;
      quo  <= '0;
      dcnt <= '0;
    end
    // Restoring division, one quotient bit per cycle; the quotient saturates.
    if (cmd.div_step) begin
      acc  <= {acc[94:0], 1'b0};
      rem  <= do_sub ? rem_shift - den : rem_shift;
      quo  <= (quo_shift > 34'h100000000) ? 33'h100000000 : quo_shift[32:0];
      dcnt <= dcnt + 7'd1;
    end
  end

  assign q_neg = (quo > 33'h080000000) ? 33'h080000000 : quo;
  assign res   = (s_reg[31] ^ num[64]) ? 32'd0 - q_neg[31:0]
               : ((quo > 33'h07fffffff) ? 32'h7fffffff : quo[31:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      limited  <= gain_on ? res : s_reg;
      limiting <= gain_on;
    end
  end

  assign st.pass_now   = bypassed &&
                         ($signed({s_reg[31], s_reg}) < $signed({2'b00, cfg.threshold}));
  assign st.count_zero = (count == '0);
  assign st.back_pop   = (rdata[31:0] <= mag);
  assign st.head_old   = ({1'b0, age} >= w_eff);
  assign st.peak_low   = (peak < {1'b0, cfg.threshold});
  assign st.gain_ok    = (cfg.input_peak > cfg.threshold) && (peak != 32'd0);
  assign st.div_last   = (dcnt == 7'd95);
  assign st.out_free   = !out_valid || !out_stall;

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for sliding_peak_soft_limiter_unit: a queue-fed
// driver and a clocked monitor check every output word against a predictor.
// Depends on spl_pkg and the limiter RTL.
`default_nettype none
module tb_top;

  localparam int          QCAP       = spl_pkg::MAX_WINDOW_DEF + 2;
  localparam int          HOLD_LEN   = 3000;
  localparam int          DRAIN_WAIT = 200;
  localparam longint      CYCLE_MAX  = 3000000;

  localparam logic [31:0] CORNER_WORDS [14] = '{32'd0, 32'hffff9001, 32'd28670,
    32'd28671, 32'h80000000, 32'd1, 32'hffffffff, 32'h7fffffff, 32'h80000001,
    32'd32767, 32'hffff8000, 32'd100, 32'h55555555, 32'haaaaaaaa};
  localparam logic [31:0] WIN1_WORDS [6] = '{32'd5000, 32'd10, 32'hffffec78,
    32'd999, 32'd40000, 32'd0};
  localparam logic [31:0] ZERO_THR_WORDS [4] = '{32'd0, 32'd0, 32'd7, 32'h80000000};

  typedef struct {
    logic [31:0] limited;
    logic        limiting;
  } limiter_out_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] sample;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] limited;
  logic        limiting;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_data;

  sliding_peak_soft_limiter_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .limited(limited), .limiting(limiting),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the limiter's registers and tracker state.
  logic [30:0] thr_q, ceil_q, ipeak_q;
  logic [14:0] win_q;
  logic [15:0] smp_count;
  logic [15:0] pk_idx [QCAP];
  logic [31:0] pk_mag [QCAP];
  int unsigned pk_head, pk_tail, pk_count;
  logic        in_bypass;

  logic [31:0]  pending_samples[$];
  limiter_out_t expected_words[$];
  int           errors;
  longint       cycles;
  bit           hold_go;
  bit           hold_done;
  int           hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Exact sign(s)*trunc(|s*num|/den), saturated to 32 bits.
  function automatic logic [31:0] gain_scale(input longint s, input longint num,
                                             input longint unsigned den);
    logic [127:0]          prod;
    logic [127:0]          quo;
    longint unsigned       ms, mn;
    bit                    neg;
    if (s == 0 || num == 0) return 32'd0;
    neg  = (s < 0) != (num < 0);
    ms   = s < 0 ? -s : s;
    mn   = num < 0 ? -num : num;
    prod = {64'd0, ms} * {64'd0, mn};
    quo  = prod / {64'd0, den};
    if (neg) begin
      if (quo > 128'h80000000) quo = 128'h80000000;
      return -quo[31:0];
    end
    if (quo > 128'h7fffffff) quo = 128'h7fffffff;
    return quo[31:0];
  endfunction

  function automatic void predict_limit(input logic [31:0] smp);
    longint       s, t, span, num, pk;
    longint unsigned den;
    logic [31:0]  mag, peak;
    int unsigned  w, back;
    limiter_out_t o;
    bit           popping;
    s = longint'($signed(smp));
    w = win_q > spl_pkg::MAX_WINDOW_DEF ? spl_pkg::MAX_WINDOW_DEF : win_q;
    o.limited  = smp;
    o.limiting = 1'b0;
    smp_count  = smp_count + 16'd1;
    if (!(in_bypass && s < longint'(thr_q))) begin
      mag = s < 0 ? 32'(-s) : 32'(s);
      popping = 1'b1;
      while (pk_count > 0 && popping) begin
        back = (pk_tail + QCAP - 1) % QCAP;
        if (pk_mag[back] > mag) popping = 1'b0;
        else begin
          pk_tail = back;
          pk_count--;
        end
      end
      pk_idx[pk_tail] = smp_count;
      pk_mag[pk_tail] = mag;
      pk_tail = (pk_tail + 1) % QCAP;
      pk_count++;
      while (pk_count > 0 && 32'(16'(smp_count - pk_idx[pk_head])) >= w) begin
        pk_head = (pk_head + 1) % QCAP;
        pk_count--;
      end
      if (pk_count > 0) begin
        peak = pk_mag[pk_head];
        if (peak < {1'b0, thr_q}) begin
          in_bypass = 1'b1;
          pk_head = 0;
          pk_tail = 0;
          pk_count = 0;
        end else begin
          in_bypass = 1'b0;
          if (ipeak_q > thr_q && peak != 0) begin
            t    = longint'(thr_q);
            pk   = longint'({32'd0, peak});
            span = longint'(ipeak_q) - t;
            num  = (longint'(ceil_q) - t) * (pk - t) + t * span;
            den  = longint'(span) * pk;
            o.limited  = gain_scale(s, num, den);
            o.limiting = 1'b1;
          end
        end
      end
    end
    expected_words.push_back(o);
  endfunction

  // Driver: bursts of words separated by random gaps.
  int burst_left, gap_left;
  always @(posedge clk) begin
    logic        nxt_valid;
    logic [31:0] nxt_sample;
    if (rst) begin
      in_valid   <= 1'b0;
      sample     <= 32'd0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      nxt_valid  = in_valid;
      nxt_sample = sample;
      if (in_valid && !in_stall) begin
        predict_limit(sample);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_samples.size() > 0) begin
          nxt_valid  = 1'b1;
          nxt_sample = pending_samples.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(40, 1);
            gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(300, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
      in_valid <= nxt_valid;
      sample   <= nxt_sample;
    end
  end

  // Receiver stall: changes its pattern every so often; one long hold-off.
  int stall_mode, stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(2);
        stall_left <= $urandom_range(400, 20);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(9) < 3);
        default: out_stall <= ($urandom_range(9) < 8);
      endcase
    end
  end

  // Monitor.
  always @(posedge clk) begin
    limiter_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", limited, 32'd0);
      end else begin
        e = expected_words.pop_front();
        if (limited !== e.limited) report_mismatch("limited", limited, e.limited);
        if (limiting !== e.limiting)
          report_mismatch("limiting", {31'd0, limiting}, {31'd0, e.limiting});
      end
    end
  end

  task automatic wait_idle();
    while (pending_samples.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_config(input logic [30:0] thr, input logic [30:0] ceil_v,
                            input logic [30:0] ip, input logic [14:0] win);
    logic [30:0] vals [4];
    wait_idle();
    vals[0] = thr;
    vals[1] = ceil_v;
    vals[2] = ip;
    vals[3] = {16'd0, win};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
    thr_q   = thr;
    ceil_q  = ceil_v;
    ipeak_q = ip;
    win_q   = win;
  endtask

  function automatic logic [31:0] clamp_word(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return 32'(v);
  endfunction

  // Runs of loud words, quiet words, words near threshold and raw noise.
  task automatic queue_program(input int count);
    int     kind, run;
    longint t, m;
    t = longint'(thr_q);
    while (count > 0) begin
      kind = $urandom_range(9);
      run  = $urandom_range(30, 1);
      for (int i = 0; i < run && count > 0; i++) begin
        case (kind)
          0, 1: m = longint'($signed($urandom));
          2, 3: m = t + longint'($urandom_range(200)) - 100
                    + ($urandom_range(1) ? longint'($urandom_range(32'(t / 4 + 1))) : 0);
          4, 5, 6: m = t + longint'($urandom_range(32'((t < 64'd1000000000) ? t + 1000 : t / 2)));
          7, 8: m = t > 0 ? longint'($urandom_range(32'(t - 1))) : 0;
          default: m = $urandom_range(1) ? 0 : 64'sd2147483647;
        endcase
        if (kind != 0 && kind != 1 && $urandom_range(1)) m = -m;
        pending_samples.push_back(clamp_word(m));
        count--;
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = spl_pkg::REG_THRESHOLD;
    cfg_data  = '0;
    errors    = 0;
    cycles    = 0;
    hold_go   = 1'b0;
    thr_q     = spl_pkg::THRESHOLD_RST;
    ceil_q    = spl_pkg::CEILING_RST;
    ipeak_q   = spl_pkg::INPUT_PEAK_RST;
    win_q     = spl_pkg::WINDOW_LEN_RST;
    smp_count = 16'd0;
    pk_head   = 0;
    pk_tail   = 0;
    pk_count  = 0;
    in_bypass = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, negative words while bypassed, the bypass wake-up
    // and the fall back into bypass.
    for (int i = 0; i < 14; i++) pending_samples.push_back(CORNER_WORDS[i]);
    // Window of one: the peak drops below threshold on the next quiet word.
    set_config(31'd1000, 31'd1500, 31'd40000, 15'd1);
    for (int i = 0; i < 6; i++) pending_samples.push_back(WIN1_WORDS[i]);
    // Zero threshold: a zero peak leaves the gain undefined.
    set_config(31'd0, 31'd0, 31'd1, 15'd16384);
    for (int i = 0; i < 4; i++) pending_samples.push_back(ZERO_THR_WORDS[i]);

    // Random phases; the long receiver hold-off falls in the first one.
    set_config(31'd1000, 31'd1500, 31'd40000, 15'd20);
    hold_go = 1'b1;
    queue_program(90);
    set_config(31'h7ffffffe, 31'h7fffffff, 31'h7fffffff, 15'd32767);
    queue_program(70);
    set_config(31'd5000, 31'd100, 31'd3000, 15'd8);
    queue_program(70);
    set_config(31'd20000, 31'h7fffffff, 31'd20001, 15'd50);
    queue_program(80);
    set_config(31'd0, 31'h7fffffff, 31'h7fffffff, 15'd3);
    queue_program(60);
    set_config(spl_pkg::THRESHOLD_RST, spl_pkg::CEILING_RST, spl_pkg::INPUT_PEAK_RST,
               15'd200);
    queue_program(90);
    for (int p = 0; p < 4; p++) begin
      set_config(31'($urandom_range(32'h7ffffffe)), 31'($urandom),
                 31'($urandom_range(32'h7fffffff, 1)), 15'($urandom_range(300, 1)));
      queue_program(70);
    end
    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
